@@ design/fan_speed_mode_controller_macros.svh @@
// ----------------------------------------------------------------------------
// fan_speed_mode_controller_macros
// assertion helpers used by the checker file fsmc_checker
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_MODE_CONTROLLER_MACROS_SVH
`define FAN_SPEED_MODE_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FSMC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fan controller check failed");

// next-cycle implication, sampled on clk, off during reset
`define FSMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fan controller check failed");

`endif

@@ design/fsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsmc_pkg
// types, codes and constants of the fan speed and mode controller
// ----------------------------------------------------------------------------
package fsmc_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // item kinds carried on the slave tuser
    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_SAMPLE      = 3'd1,
        ACT_HOST_AUTO   = 3'd2,
        ACT_HOST_MANUAL = 3'd3,
        ACT_HOST_SPEED  = 3'd4
    } action_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOCKOUT_MS = 3'd0,
        CFG_TEMP_LOW   = 3'd1,
        CFG_TEMP_MID   = 3'd2,
        CFG_TEMP_HIGH  = 3'd3,
        CFG_HUM_LOW    = 3'd4,
        CFG_HUM_HIGH   = 3'd5,
        CFG_SPEED_STEP = 3'd6
    } cfg_index_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [5:0]         pad;
        logic               host_speed_given;
        logic signed [15:0] host_speed;
        logic               sample_valid;
        logic [9:0]         hum_sample;
        logic signed [10:0] temp_sample;
        logic               down_button;
        logic               up_button;
        logic               mode_button;
    } in_fields_t;

    typedef struct packed {
        logic [2:0] pad;
        logic       tone_down;
        logic       tone_up;
        logic       tone_mode;
        logic [6:0] manual_level;
        logic       manual_mode;
        logic [2:0] bar_count;
        logic [7:0] pwm_duty;
        logic [6:0] fan_percent;
    } out_fields_t;

    // register reset values
    localparam logic [9:0]         LOCKOUT_RST    = 10'd200;
    localparam logic signed [10:0] TEMP_LOW_RST   = 11'sd250;
    localparam logic signed [10:0] TEMP_MID_RST   = 11'sd280;
    localparam logic signed [10:0] TEMP_HIGH_RST  = 11'sd320;
    localparam logic [9:0]         HUM_LOW_RST    = 10'd600;
    localparam logic [9:0]         HUM_HIGH_RST   = 10'd700;
    localparam logic [6:0]         SPEED_STEP_RST = 7'd10;

    localparam logic [9:0] SINCE_MAX = 10'd1023;

    // speed ladder levels
    localparam logic [6:0] SPEED_MAX  = 7'd100;
    localparam logic [6:0] T_SPEED_0  = 7'd0;
    localparam logic [6:0] T_SPEED_1  = 7'd30;
    localparam logic [6:0] T_SPEED_2  = 7'd60;
    localparam logic [6:0] T_SPEED_3  = 7'd100;
    localparam logic [6:0] H_SPEED_LO = 7'd20;
    localparam logic [6:0] H_SPEED_MI = 7'd40;
    localparam logic [6:0] H_SPEED_HI = 7'd80;

    // pct*255/100 and pct/20 as reciprocal multiplies, exact for 0..127
    localparam logic [20:0] PWM_MUL   = 21'd1336965;
    localparam int          PWM_SHIFT = 19;
    localparam logic [11:0] BAR_MUL   = 12'd3277;
    localparam int          BAR_SHIFT = 16;

endpackage

@@ design/fan_speed_mode_controller.sv @@
// ----------------------------------------------------------------------------
// fan_speed_mode_controller
// button, sensor and host driven fan speed with pwm duty and bar display
// ----------------------------------------------------------------------------
//
//  channel   signals                              one request
//  --------  -----------------------------------  ------------------------------
//  s_axis    s_tvalid s_tready s_tuser s_tdata    tick, sensor sample or host item
//  m_axis    m_tvalid m_tready m_tdata            speed report, one per input
//  cfg       cfg_valid cfg_ready cfg_index        register write, always taken
//            cfg_data
//
//  one request a clock unless m_tready stalls: input register, logic, result
//  register; m_tvalid rises as a request moves from the input register to the
//  result register. the input register can still take a request while a result
//  waits on m_tready; it holds only when both registers are full and m_tready is
//  low
//  rst_n clears both valid flags, the fan state and the registers to defaults
//
module fan_speed_mode_controller
(
    input  logic                               clk,
    input  logic                               rst_n,
    // slave stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fsmc_pkg::IN_USER_W-1:0]     s_tuser,   // action
    // mode_button, up_button, down_button, temp_sample, hum_sample,
    // sample_valid, host_speed, host_speed_given, zero pad
    input  logic [fsmc_pkg::IN_DATA_W-1:0]     s_tdata,
    // master stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fan_percent, pwm_duty, bar_count, manual_mode, manual_level,
    // tone_mode, tone_up, tone_down, zero pad
    output logic [fsmc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fsmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [9:0]         lockout_ms_reg;
    logic signed [10:0] temp_low_reg;
    logic signed [10:0] temp_mid_reg;
    logic signed [10:0] temp_high_reg;
    logic [9:0]         hum_low_reg;
    logic [9:0]         hum_high_reg;
    logic [6:0]         speed_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_ms_reg <= fsmc_pkg::LOCKOUT_RST;
            temp_low_reg   <= fsmc_pkg::TEMP_LOW_RST;
            temp_mid_reg   <= fsmc_pkg::TEMP_MID_RST;
            temp_high_reg  <= fsmc_pkg::TEMP_HIGH_RST;
            hum_low_reg    <= fsmc_pkg::HUM_LOW_RST;
            hum_high_reg   <= fsmc_pkg::HUM_HIGH_RST;
            speed_step_reg <= fsmc_pkg::SPEED_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (fsmc_pkg::cfg_index_t'(cfg_index))
                fsmc_pkg::CFG_LOCKOUT_MS: lockout_ms_reg <= cfg_data[9:0];
                fsmc_pkg::CFG_TEMP_LOW:   temp_low_reg   <= cfg_data;
                fsmc_pkg::CFG_TEMP_MID:   temp_mid_reg   <= cfg_data;
                fsmc_pkg::CFG_TEMP_HIGH:  temp_high_reg  <= cfg_data;
                fsmc_pkg::CFG_HUM_LOW:    hum_low_reg    <= cfg_data[9:0];
                fsmc_pkg::CFG_HUM_HIGH:   hum_high_reg   <= cfg_data[9:0];
                fsmc_pkg::CFG_SPEED_STEP: speed_step_reg <= cfg_data[6:0];
                default: ;  // index past the list is dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register and result register handshake
    // ------------------------------------------------------------------
    logic                                   in_valid_reg;
    logic [fsmc_pkg::IN_USER_W-1:0]         in_user_reg;
    fsmc_pkg::in_fields_t                   in_data_reg;
    logic                                   out_valid_reg;
    fsmc_pkg::out_fields_t                  out_data_reg;
    fsmc_pkg::out_fields_t                  out_data_next;
    logic                                   advance;

    // the held request moves into the result register when that is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_user_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------
    // fan state, updated as each request passes to the result register
    // ------------------------------------------------------------------
    logic               mode_manual_reg,  mode_manual_next;
    logic [6:0]         manual_pct_reg,   manual_pct_next;
    logic signed [10:0] temp_held_reg,    temp_held_next;
    logic [9:0]         hum_held_reg,     hum_held_next;
    logic               prev_mode_reg,    prev_mode_next;
    logic               prev_up_reg,      prev_up_next;
    logic               prev_down_reg,    prev_down_next;
    logic [9:0]         since_press_reg,  since_press_next;
    logic               tone_mode_next, tone_up_next, tone_down_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_manual_reg <= 1'b0;
            manual_pct_reg  <= '0;
            temp_held_reg   <= '0;
            hum_held_reg    <= '0;
            prev_mode_reg   <= 1'b1;
            prev_up_reg     <= 1'b1;
            prev_down_reg   <= 1'b1;
            since_press_reg <= '0;
        end
        else if (advance)
        begin
            mode_manual_reg <= mode_manual_next;
            manual_pct_reg  <= manual_pct_next;
            temp_held_reg   <= temp_held_next;
            hum_held_reg    <= hum_held_next;
            prev_mode_reg   <= prev_mode_next;
            prev_up_reg     <= prev_up_next;
            prev_down_reg   <= prev_down_next;
            since_press_reg <= since_press_next;
        end
    end

    // host speed limited to 0..100
    logic [6:0] host_pct;

    always_comb
    begin
        if (in_data_reg.host_speed < 16'sd0)
        begin
            host_pct = '0;
        end
        else if (in_data_reg.host_speed > 16'sd100)
        begin
            host_pct = fsmc_pkg::SPEED_MAX;
        end
        else
        begin
            host_pct = in_data_reg.host_speed[6:0];
        end
    end

    // ------------------------------------------------------------------
    // next state for the held request
    // ------------------------------------------------------------------
    logic [9:0] since_inc;
    logic [7:0] up_sum;
    logic [6:0] after_up;
    logic       up_edge;
    logic       down_edge;
    logic       mode_edge;

    always_comb
    begin
        mode_manual_next = mode_manual_reg;
        manual_pct_next  = manual_pct_reg;
        temp_held_next   = temp_held_reg;
        hum_held_next    = hum_held_reg;
        prev_mode_next   = prev_mode_reg;
        prev_up_next     = prev_up_reg;
        prev_down_next   = prev_down_reg;
        since_press_next = since_press_reg;
        tone_mode_next   = 1'b0;
        tone_up_next     = 1'b0;
        tone_down_next   = 1'b0;

        since_inc = (since_press_reg == fsmc_pkg::SINCE_MAX)
                  ? since_press_reg : since_press_reg + 10'd1;
        mode_edge = !in_data_reg.mode_button && prev_mode_reg;
        up_edge   = !in_data_reg.up_button && prev_up_reg;
        down_edge = !in_data_reg.down_button && prev_down_reg;
        up_sum    = {1'b0, manual_pct_reg} + {1'b0, speed_step_reg};
        after_up  = manual_pct_reg;

        case (fsmc_pkg::action_t'(in_user_reg))
            fsmc_pkg::ACT_TICK:
            begin
                since_press_next = since_inc;
                // buttons count only once the lockout has run out
                if (since_inc >= lockout_ms_reg)
                begin
                    prev_mode_next   = in_data_reg.mode_button;
                    mode_manual_next = mode_manual_reg ^ mode_edge;
                    tone_mode_next   = mode_edge;
                    if (mode_manual_next)
                    begin
                        prev_up_next   = in_data_reg.up_button;
                        prev_down_next = in_data_reg.down_button;
                        tone_up_next   = up_edge;
                        tone_down_next = down_edge;
                        // up first, then down on its result
                        if (up_edge)
                        begin
                            after_up = (up_sum > {1'b0, fsmc_pkg::SPEED_MAX})
                                     ? fsmc_pkg::SPEED_MAX : up_sum[6:0];
                        end
                        manual_pct_next = after_up;
                        if (down_edge)
                        begin
                            manual_pct_next = (after_up > speed_step_reg)
                                            ? after_up - speed_step_reg : '0;
                        end
                    end
                    if (mode_edge || tone_up_next || tone_down_next)
                    begin
                        since_press_next = '0;
                    end
                end
            end
            fsmc_pkg::ACT_SAMPLE:
            begin
                if (in_data_reg.sample_valid)
                begin
                    temp_held_next = in_data_reg.temp_sample;
                    hum_held_next  = in_data_reg.hum_sample;
                end
            end
            fsmc_pkg::ACT_HOST_AUTO:
            begin
                mode_manual_next = 1'b0;
            end
            fsmc_pkg::ACT_HOST_MANUAL:
            begin
                mode_manual_next = 1'b1;
                if (in_data_reg.host_speed_given)
                begin
                    manual_pct_next = host_pct;
                end
            end
            fsmc_pkg::ACT_HOST_SPEED:
            begin
                if (mode_manual_reg)
                begin
                    manual_pct_next = host_pct;
                end
            end
            default: ;  // unused kinds only report
        endcase
    end

    // ------------------------------------------------------------------
    // report from the state after the request
    // ------------------------------------------------------------------
    logic [6:0]  temp_speed;
    logic [6:0]  hum_speed;
    logic [6:0]  fan_pct;
    logic [27:0] pwm_prod;
    logic [18:0] bar_prod;

    always_comb
    begin
        if (temp_held_next < temp_low_reg)
        begin
            temp_speed = fsmc_pkg::T_SPEED_0;
        end
        else if (temp_held_next < temp_mid_reg)
        begin
            temp_speed = fsmc_pkg::T_SPEED_1;
        end
        else if (temp_held_next < temp_high_reg)
        begin
            temp_speed = fsmc_pkg::T_SPEED_2;
        end
        else
        begin
            temp_speed = fsmc_pkg::T_SPEED_3;
        end

        if (hum_held_next < hum_low_reg)
        begin
            hum_speed = fsmc_pkg::H_SPEED_LO;
        end
        else if (hum_held_next > hum_high_reg)
        begin
            hum_speed = fsmc_pkg::H_SPEED_HI;
        end
        else
        begin
            hum_speed = fsmc_pkg::H_SPEED_MI;
        end

        if (mode_manual_next)
        begin
            fan_pct = manual_pct_next;
        end
        else
        begin
            fan_pct = (temp_speed > hum_speed) ? temp_speed : hum_speed;
        end
    end

    // constant reciprocal multiplies stand in for the divides by 100
    assign pwm_prod = 28'(fan_pct) * 28'(fsmc_pkg::PWM_MUL);
    assign bar_prod = 19'(fan_pct) * 19'(fsmc_pkg::BAR_MUL);

    always_comb
    begin
        out_data_next              = '0;
        out_data_next.fan_percent  = fan_pct;
        out_data_next.pwm_duty     = 8'(pwm_prod >> fsmc_pkg::PWM_SHIFT);
        out_data_next.bar_count    = 3'(bar_prod >> fsmc_pkg::BAR_SHIFT);
        out_data_next.manual_mode  = mode_manual_next;
        out_data_next.manual_level = manual_pct_next;
        out_data_next.tone_mode    = tone_mode_next;
        out_data_next.tone_up      = tone_up_next;
        out_data_next.tone_down    = tone_down_next;
    end

endmodule

@@ design/fsmc_checker.sv @@
// ----------------------------------------------------------------------------
// fsmc_checker
// port level checks of the fan speed and mode controller
// ----------------------------------------------------------------------------
`include "fan_speed_mode_controller_macros.svh"

module fsmc_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [fsmc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    fsmc_pkg::out_fields_t rpt;
    logic [15:0]           pwm_calc;
    logic [15:0]           bar_calc;

    assign rpt      = m_tdata;
    assign pwm_calc = (16'(rpt.fan_percent) * 16'd255) / 16'd100;
    assign bar_calc = (16'(rpt.fan_percent) * 16'd5) / 16'd100;

    // a stalled report stays put
    `FSMC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // duty and bars follow the speed
    `FSMC_ASSERT_NOW(a_scaling, m_tvalid,
        rpt.pwm_duty == pwm_calc[7:0] && rpt.bar_count == bar_calc[2:0]
        && rpt.fan_percent <= fsmc_pkg::SPEED_MAX)

    // manual mode shows the stored manual speed
    `FSMC_ASSERT_NOW(a_manual_speed, m_tvalid && rpt.manual_mode,
        rpt.fan_percent == rpt.manual_level)

    // step tones only ever come in manual mode
    `FSMC_ASSERT_NOW(a_step_tone, m_tvalid && (rpt.tone_up || rpt.tone_down),
        rpt.manual_mode)

endmodule

bind fan_speed_mode_controller fsmc_checker u_fsmc_checker (.*);

@@ tb/sv/fan_speed_mode_controller_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_speed_mode_controller_test
// self-checking bench for the fan speed and mode controller
//
// a directed list walks the sensor ladders, host items, undefined actions and
// the button lockout, then random requests run under several register
// settings and three idling patterns. every report is compared field by field
// with an in-bench prediction of the controller state or a typed report.
// ----------------------------------------------------------------------------
module fan_speed_mode_controller_test;

    typedef fsmc_pkg::in_fields_t  in_fields_t;
    typedef fsmc_pkg::out_fields_t out_fields_t;

    localparam int QUIET_LIMIT      = 5000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES    = 4;     // settling margin after the reports drain
    localparam int TAIL_CYCLES      = 20;
    localparam int RANDOM_PER_CHUNK = 160;

    // actions outside the defined set, reported without a state change
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    // register index past the last register, the write is dropped
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_TYPED,
        ROW_SETTING
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  act;
        in_fields_t  fields;
        out_fields_t report;
        logic [2:0]  reg_index;
        logic [10:0] reg_value;
    } plan_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [fsmc_pkg::IN_USER_W-1:0]  s_tuser;   // action
    // mode_button, up_button, down_button, temp_sample, hum_sample,
    // sample_valid, host_speed, host_speed_given, zero pad
    logic [fsmc_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // fan_percent, pwm_duty, bar_count, manual_mode, manual_level,
    // tone_mode, tone_up, tone_down, zero pad
    logic [fsmc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [fsmc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fsmc_pkg::CFG_DATA_W-1:0] cfg_data;

    // predicted controller state
    logic               manual_on;
    logic [6:0]         level_pct;
    logic signed [10:0] temp_now;
    logic [9:0]         hum_now;
    logic               last_mode_lvl;
    logic               last_up_lvl;
    logic               last_down_lvl;
    logic [9:0]         since_ms;

    // predicted register contents
    logic [9:0]         lockout_set;
    logic signed [10:0] temp_low_set;
    logic signed [10:0] temp_mid_set;
    logic signed [10:0] temp_high_set;
    logic [9:0]         hum_low_set;
    logic [9:0]         hum_high_set;
    logic [6:0]         step_set;

    out_fields_t awaited_fan_reports[$];
    plan_row_t   directed_plan[$];

    // a typed row overrides the prediction for its own report
    logic        typed_active;
    out_fields_t typed_report;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // held button levels for the random part, 1 means released
    logic btn_mode;
    logic btn_up;
    logic btn_down;

    int unsigned requests_taken;
    int unsigned reports_seen;
    int unsigned settings_taken;
    int unsigned fault_count;
    int unsigned toggles_seen;
    int unsigned ups_seen;
    int unsigned downs_seen;

    fan_speed_mode_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_fields_t fields_of(input logic mb, input logic ub,
                                             input logic db, input int temp,
                                             input int hum, input logic sv,
                                             input int hs, input logic hsg);
        in_fields_t f;
        f                  = '0;
        f.mode_button      = mb;
        f.up_button        = ub;
        f.down_button      = db;
        f.temp_sample      = 11'(temp);
        f.hum_sample       = 10'(hum);
        f.sample_valid     = sv;
        f.host_speed       = 16'(hs);
        f.host_speed_given = hsg;
        return f;
    endfunction

    function automatic out_fields_t report_of(input int fan, input int pwm, input int bar,
                                              input logic mode, input int lvl,
                                              input logic tm, input logic tu,
                                              input logic td);
        out_fields_t r;
        r              = '0;
        r.fan_percent  = 7'(fan);
        r.pwm_duty     = 8'(pwm);
        r.bar_count    = 3'(bar);
        r.manual_mode  = mode;
        r.manual_level = 7'(lvl);
        r.tone_mode    = tm;
        r.tone_up      = tu;
        r.tone_down    = td;
        return r;
    endfunction

    function automatic int clamp_pct(input logic signed [15:0] v);
        int s;
        s = v;
        if (s < 0)
        begin
            return 0;
        end
        return (s > 100) ? 100 : s;
    endfunction

    function automatic void apply_setting(input logic [2:0] idx, input logic [10:0] val);
        case (idx)
            fsmc_pkg::CFG_LOCKOUT_MS: lockout_set   = val[9:0];
            fsmc_pkg::CFG_TEMP_LOW:   temp_low_set  = $signed(val);
            fsmc_pkg::CFG_TEMP_MID:   temp_mid_set  = $signed(val);
            fsmc_pkg::CFG_TEMP_HIGH:  temp_high_set = $signed(val);
            fsmc_pkg::CFG_HUM_LOW:    hum_low_set   = val[9:0];
            fsmc_pkg::CFG_HUM_HIGH:   hum_high_set  = val[9:0];
            fsmc_pkg::CFG_SPEED_STEP: step_set      = val[6:0];
            default: ;
        endcase
    endfunction

    // advances the predicted state by one request and returns its report
    function automatic out_fields_t predict_fan_report(input logic [2:0] act,
                                                       input in_fields_t f);
        out_fields_t r;
        int          lvl;
        int          fan;
        int          t_pct;
        int          h_pct;
        r   = '0;
        lvl = level_pct;
        case (act)
            fsmc_pkg::ACT_TICK:
            begin
                if (since_ms != fsmc_pkg::SINCE_MAX)
                begin
                    since_ms = since_ms + 10'd1;
                end
                // inside the lockout window the levels are not even stored
                if (since_ms >= lockout_set)
                begin
                    if (!f.mode_button && last_mode_lvl)
                    begin
                        manual_on   = ~manual_on;
                        since_ms    = '0;
                        r.tone_mode = 1'b1;
                    end
                    last_mode_lvl = f.mode_button;
                    // up and down only count in manual mode, after the toggle
                    if (manual_on)
                    begin
                        if (!f.up_button && last_up_lvl)
                        begin
                            lvl       = lvl + step_set;
                            lvl       = (lvl > 100) ? 100 : lvl;
                            since_ms  = '0;
                            r.tone_up = 1'b1;
                        end
                        if (!f.down_button && last_down_lvl)
                        begin
                            lvl         = (lvl > step_set) ? lvl - step_set : 0;
                            since_ms    = '0;
                            r.tone_down = 1'b1;
                        end
                        last_up_lvl   = f.up_button;
                        last_down_lvl = f.down_button;
                    end
                end
            end
            fsmc_pkg::ACT_SAMPLE:
            begin
                if (f.sample_valid)
                begin
                    temp_now = f.temp_sample;
                    hum_now  = f.hum_sample;
                end
            end
            fsmc_pkg::ACT_HOST_AUTO:
            begin
                manual_on = 1'b0;
            end
            fsmc_pkg::ACT_HOST_MANUAL:
            begin
                manual_on = 1'b1;
                if (f.host_speed_given)
                begin
                    lvl = clamp_pct(f.host_speed);
                end
            end
            fsmc_pkg::ACT_HOST_SPEED:
            begin
                if (manual_on)
                begin
                    lvl = clamp_pct(f.host_speed);
                end
            end
            default: ;
        endcase
        level_pct = 7'(lvl);

        // auto speed is the larger of the temperature and humidity ladders
        if (temp_now < temp_low_set)
        begin
            t_pct = 0;
        end
        else if (temp_now < temp_mid_set)
        begin
            t_pct = 30;
        end
        else if (temp_now < temp_high_set)
        begin
            t_pct = 60;
        end
        else
        begin
            t_pct = 100;
        end
        if (hum_now < hum_low_set)
        begin
            h_pct = 20;
        end
        else if (hum_now > hum_high_set)
        begin
            h_pct = 80;
        end
        else
        begin
            h_pct = 40;
        end

        fan            = manual_on ? lvl : ((t_pct > h_pct) ? t_pct : h_pct);
        r.fan_percent  = 7'(fan);
        r.pwm_duty     = 8'(fan * 255 / 100);
        r.bar_count    = 3'(fan * 5 / 100);
        r.manual_mode  = manual_on;
        r.manual_level = level_pct;
        return r;
    endfunction

    function automatic void compare_report(input out_fields_t got);
        out_fields_t want;
        reports_seen++;
        if (awaited_fan_reports.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
            begin
                $display("report %0d arrived with no request outstanding", reports_seen);
            end
            return;
        end
        want = awaited_fan_reports.pop_front();
        if (got.fan_percent != want.fan_percent || got.pwm_duty != want.pwm_duty
            || got.bar_count != want.bar_count || got.manual_mode != want.manual_mode
            || got.manual_level != want.manual_level || got.tone_mode != want.tone_mode
            || got.tone_up != want.tone_up || got.tone_down != want.tone_down)
        begin
            fault_count++;
            if (fault_count <= 10)
            begin
                $display({"report %0d expected fan %0d pwm %0d bar %0d manual %0d",
                          " level %0d tones %b%b%b"},
                         reports_seen, want.fan_percent, want.pwm_duty, want.bar_count,
                         want.manual_mode, want.manual_level,
                         want.tone_mode, want.tone_up, want.tone_down);
                $display({"report %0d actual   fan %0d pwm %0d bar %0d manual %0d",
                          " level %0d tones %b%b%b"},
                         reports_seen, got.fan_percent, got.pwm_duty, got.bar_count,
                         got.manual_mode, got.manual_level,
                         got.tone_mode, got.tone_up, got.tone_down);
            end
        end
        toggles_seen += got.tone_mode;
        ups_seen     += got.tone_up;
        downs_seen   += got.tone_down;
    endfunction

    // every handshake is observed at the rising edge, before the block updates
    always @(posedge clk)
    begin : observe
        out_fields_t want;
        if (rst_n)
        begin
            // results first, so a request taken on the same edge cannot cover a stray one
            if (m_tvalid && m_tready)
            begin
                compare_report(out_fields_t'(m_tdata));
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_fan_report(s_tuser, in_fields_t'(s_tdata));
                if (typed_active)
                begin
                    want = typed_report;
                end
                awaited_fan_reports.push_back(want);
                requests_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_setting(cfg_index, cfg_data);
                settings_taken++;
            end
        end
    end

    // receiver back-pressure, drawn fresh every cycle
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ends the run when no channel moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input logic [2:0] act, input in_fields_t fields,
                                input logic typed, input out_fields_t typed_value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid     <= 1'b1;
        s_tuser      <= act;
        s_tdata      <= fields;
        typed_active <= typed;
        typed_report <= typed_value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // sender holds off until every outstanding report has come back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_fan_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [10:0] val);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input int lockout, input int t_lo, input int t_mid,
                                 input int t_hi, input int h_lo, input int h_hi,
                                 input int step);
        write_setting(fsmc_pkg::CFG_LOCKOUT_MS, 11'(lockout));
        write_setting(fsmc_pkg::CFG_TEMP_LOW, 11'(t_lo));
        write_setting(fsmc_pkg::CFG_TEMP_MID, 11'(t_mid));
        write_setting(fsmc_pkg::CFG_TEMP_HIGH, 11'(t_hi));
        write_setting(fsmc_pkg::CFG_HUM_LOW, 11'(h_lo));
        write_setting(fsmc_pkg::CFG_HUM_HIGH, 11'(h_hi));
        write_setting(fsmc_pkg::CFG_SPEED_STEP, 11'(step));
    endtask

    // mostly button press and release sequences on ticks, mixed with sensor
    // samples, host items and undefined actions
    task automatic send_random_request();
        int unsigned pick;
        logic [2:0]  act;
        in_fields_t  f;
        pick               = $urandom_range(0, 99);
        f                  = '0;
        f.mode_button      = 1'($urandom_range(0, 1));
        f.up_button        = 1'($urandom_range(0, 1));
        f.down_button      = 1'($urandom_range(0, 1));
        f.temp_sample      = ($urandom_range(0, 9) == 0)
                           ? 11'($urandom) : 11'($urandom_range(0, 1200) - 400);
        f.hum_sample       = ($urandom_range(0, 6) == 0)
                           ? 10'($urandom) : 10'($urandom_range(0, 1000));
        f.sample_valid     = ($urandom_range(0, 4) != 0);
        f.host_speed       = ($urandom_range(0, 1) == 0)
                           ? 16'($urandom) : 16'($urandom_range(0, 150) - 25);
        f.host_speed_given = 1'($urandom_range(0, 1));
        if (pick < 55)
        begin
            act = fsmc_pkg::ACT_TICK;
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: levels jump anywhere
                btn_mode = f.mode_button;
                btn_up   = f.up_button;
                btn_down = f.down_button;
            end
            else
            begin
                if ($urandom_range(0, 99) < 35) btn_mode = ~btn_mode;
                if ($urandom_range(0, 99) < 35) btn_up   = ~btn_up;
                if ($urandom_range(0, 99) < 35) btn_down = ~btn_down;
            end
            f.mode_button = btn_mode;
            f.up_button   = btn_up;
            f.down_button = btn_down;
        end
        else if (pick < 70)
        begin
            act = fsmc_pkg::ACT_SAMPLE;
        end
        else if (pick < 76)
        begin
            act = fsmc_pkg::ACT_HOST_AUTO;
        end
        else if (pick < 84)
        begin
            act = fsmc_pkg::ACT_HOST_MANUAL;
        end
        else if (pick < 94)
        begin
            act = fsmc_pkg::ACT_HOST_SPEED;
        end
        else
        begin
            act = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
        end
        send_request(act, f, 1'b0, '0);
    endtask

    initial
    begin : stimulus
        in_fields_t released;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = '0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        typed_active = 1'b0;
        typed_report = '0;

        manual_on     = 1'b0;
        level_pct     = '0;
        temp_now      = '0;
        hum_now       = '0;
        last_mode_lvl = 1'b1;
        last_up_lvl   = 1'b1;
        last_down_lvl = 1'b1;
        since_ms      = '0;
        lockout_set   = fsmc_pkg::LOCKOUT_RST;
        temp_low_set  = fsmc_pkg::TEMP_LOW_RST;
        temp_mid_set  = fsmc_pkg::TEMP_MID_RST;
        temp_high_set = fsmc_pkg::TEMP_HIGH_RST;
        hum_low_set   = fsmc_pkg::HUM_LOW_RST;
        hum_high_set  = fsmc_pkg::HUM_HIGH_RST;
        step_set      = fsmc_pkg::SPEED_STEP_RST;

        btn_mode       = 1'b1;
        btn_up         = 1'b1;
        btn_down       = 1'b1;
        send_idle_pct  = 11;
        recv_stall_pct = 70;
        requests_taken = 0;
        reports_seen   = 0;
        settings_taken = 0;
        fault_count    = 0;
        toggles_seen   = 0;
        ups_seen       = 0;
        downs_seen     = 0;
        released       = fields_of(1, 1, 1, 0, 0, 0, 0, 0);

        // register defaults: lockout 200, ladders 250/280/320 and 600/700
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_TICK, released,
                                  report_of(20, 51, 1, 0, 0, 0, 0, 0), '0, '0});
        // hottest and most humid reading tops both ladders
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_SAMPLE,
                                  fields_of(1, 1, 1, 800, 1000, 1, 0, 0),
                                  report_of(100, 255, 5, 0, 0, 0, 0, 0), '0, '0});
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_SAMPLE,
                                  fields_of(1, 1, 1, -400, 0, 1, 0, 0),
                                  report_of(20, 51, 1, 0, 0, 0, 0, 0), '0, '0});
        // invalid sample leaves the held reading alone
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_SAMPLE,
                                  fields_of(1, 1, 1, 800, 1000, 0, 0, 0),
                                  report_of(20, 51, 1, 0, 0, 0, 0, 0), '0, '0});
        // humidity past the nominal range is kept as given
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_SAMPLE,
                                  fields_of(1, 1, 1, 300, 1023, 1, 0, 0), '0, '0, '0});
        // host speed is ignored in auto mode
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_HOST_SPEED,
                                  fields_of(1, 1, 1, 0, 0, 0, 77, 1), '0, '0, '0});
        // host manual without a speed only switches the mode
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_HOST_MANUAL,
                                  fields_of(1, 1, 1, 0, 0, 0, 99, 0),
                                  report_of(0, 0, 0, 1, 0, 0, 0, 0), '0, '0});
        // host speed clamps at both ends of the 16-bit range
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_HOST_SPEED,
                                  fields_of(1, 1, 1, 0, 0, 0, 32767, 0),
                                  report_of(100, 255, 5, 1, 100, 0, 0, 0), '0, '0});
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_HOST_SPEED,
                                  fields_of(1, 1, 1, 0, 0, 0, -32768, 1),
                                  report_of(0, 0, 0, 1, 0, 0, 0, 0), '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_HOST_MANUAL,
                                  fields_of(1, 1, 1, 0, 0, 0, 55, 1), '0, '0, '0});
        // undefined actions only report
        directed_plan.push_back('{ROW_PREDICTED, ACT_SPARE_5,
                                  fields_of(0, 0, 0, -1, 1023, 1, -1, 1), '0, '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, ACT_SPARE_6,
                                  fields_of(0, 0, 0, 1023, 512, 1, 100, 1), '0, '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, ACT_SPARE_7, released, '0, '0, '0});
        // press inside the lockout window does nothing
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_TICK,
                                  fields_of(0, 1, 1, 0, 0, 0, 0, 0), '0, '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_HOST_AUTO, released,
                                  '0, '0, '0});
        directed_plan.push_back('{ROW_SETTING, fsmc_pkg::ACT_TICK, '0, '0,
                                  fsmc_pkg::CFG_LOCKOUT_MS, 11'd0});
        directed_plan.push_back('{ROW_SETTING, fsmc_pkg::ACT_TICK, '0, '0,
                                  fsmc_pkg::CFG_SPEED_STEP, 11'd60});
        // mode toggle then up step in the same tick, up saturates at 100
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_TICK,
                                  fields_of(0, 0, 1, 0, 0, 0, 0, 0),
                                  report_of(100, 255, 5, 1, 100, 1, 1, 0), '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_TICK, released,
                                  '0, '0, '0});
        // up and down together: up first, down on its result
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_TICK,
                                  fields_of(1, 0, 0, 0, 0, 0, 0, 0), '0, '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_TICK, released,
                                  '0, '0, '0});
        // down saturates at zero
        directed_plan.push_back('{ROW_TYPED, fsmc_pkg::ACT_TICK,
                                  fields_of(1, 1, 0, 0, 0, 0, 0, 0),
                                  report_of(0, 0, 0, 1, 0, 0, 0, 1), '0, '0});
        directed_plan.push_back('{ROW_SETTING, fsmc_pkg::ACT_TICK, '0, '0,
                                  fsmc_pkg::CFG_SPEED_STEP, 11'd0});
        // zero step still sounds the tone
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_TICK,
                                  fields_of(1, 0, 1, 0, 0, 0, 0, 0), '0, '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_TICK,
                                  fields_of(0, 1, 1, 0, 0, 0, 0, 0), '0, '0, '0});
        directed_plan.push_back('{ROW_PREDICTED, fsmc_pkg::ACT_HOST_SPEED,
                                  fields_of(1, 1, 1, 0, 0, 0, 50, 1), '0, '0, '0});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_SETTING)
            begin
                write_setting(directed_plan[i].reg_index, directed_plan[i].reg_value);
            end
            else
            begin
                send_request(directed_plan[i].act, directed_plan[i].fields,
                             directed_plan[i].kind == ROW_TYPED, directed_plan[i].report);
            end
        end

        // random part: two settings per idling pattern
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            wait_drained();
            send_idle_pct  = (chunk < 2) ? 11 : (chunk < 4) ? 70 : 0;
            recv_stall_pct = (chunk < 2) ? 70 : (chunk < 4) ? 11 : 0;
            case (chunk)
                0: load_settings(0, -400, -400, -400, 0, 0, 1);
                1: load_settings(3, $urandom_range(0, 600) - 400,
                                 $urandom_range(0, 400) + 100,
                                 $urandom_range(0, 500) + 300, $urandom_range(0, 600),
                                 $urandom_range(0, 400) + 600, $urandom_range(1, 100));
                2: load_settings(2, 800, 800, 800, 1000, 1000, 100);
                3: load_settings(0, 250, 280, 320, 600, 700, 127);
                4:
                begin
                    // full register widths, bits above a register's width are dropped
                    load_settings($urandom_range(0, 6) + 1024 * $urandom_range(0, 1),
                                  $urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom);
                    write_setting(CFG_SPARE_INDEX, 11'($urandom));
                end
                default:
                begin
                    // a real lockout window between presses
                    load_settings(20, 250, 280, 320, 600, 700, 10);
                end
            endcase
            repeat (RANDOM_PER_CHUNK) send_random_request();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d requests and %0d register writes, %0d reports compared",
                 requests_taken, settings_taken, reports_seen);
        $display("mode toggles %0d, steps up %0d, steps down %0d, faults %0d",
                 toggles_seen, ups_seen, downs_seen, fault_count);
        if (fault_count == 0 && awaited_fan_reports.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
